[rtl/core/mwt_pkg.sv]
package mwt_pkg;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int DEST_W    = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT  = 3'd0,
        REG_COL_COUNT  = 3'd1,
        REG_ROW_BEGIN  = 3'd2,
        REG_ROW_END    = 3'd3,
        REG_COL_BEGIN  = 3'd4,
        REG_COL_END    = 3'd5,
        REG_OUT_STRIDE = 3'd6
    } t_cfg_reg;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef struct packed {
        logic [6:0] row_count;
        logic [6:0] col_count;
        logic [5:0] row_begin;
        logic [6:0] row_end;
        logic [5:0] col_begin;
        logic [6:0] col_end;
        logic [6:0] out_stride;
    } t_cfg;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    typedef struct packed {
        logic ready;
        logic s1_valid;
        logic window_done;
    } t_seq_stat;

endpackage

[rtl/core/mwt_if.sv]
interface mwt_item_if #(
    parameter int ELEMENT_BITS = 32
);
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic signed [ELEMENT_BITS-1:0] element_in;

    modport source (output valid, operation, element_in, input ready);
    modport sink   (input valid, operation, element_in, output ready);
endinterface

interface mwt_result_if #(
    parameter int ELEMENT_BITS = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [ELEMENT_BITS-1:0] element_out;
    logic [mwt_pkg::DEST_W-1:0]     dest_index;
    logic                           last_of_window;

    modport source (output valid, element_out, dest_index, last_of_window, input ready);
    modport sink   (input valid, element_out, dest_index, last_of_window, output ready);
endinterface

[rtl/core/mwt_store.sv]
module mwt_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  mwt_pkg::t_mem_ctl i_ctl,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read register holds while no new read is issued
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/mwt_seq.sv]
module mwt_seq #(
    parameter int MAX_DIM      = 64,
    parameter int ELEMENT_BITS = 32,
    parameter int ADDR_W       = $clog2(MAX_DIM * MAX_DIM)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mwt_pkg::t_cfg              i_cfg,
    input  logic                       i_valid,
    input  logic                       i_op,
    input  logic [ELEMENT_BITS-1:0]    i_elem,
    input  logic                       i_take,
    output mwt_pkg::t_seq_stat         o_stat,
    output mwt_pkg::t_mem_ctl          o_mem_ctl,
    output logic [ADDR_W-1:0]          o_waddr,
    output logic [ELEMENT_BITS-1:0]    o_wdata,
    output logic [ADDR_W-1:0]          o_raddr,
    output logic [mwt_pkg::DEST_W-1:0] o_dest,
    output logic                       o_last
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int EW    = (DIM_W > mwt_pkg::CFG_W) ? DIM_W : mwt_pkg::CFG_W;
    localparam int LC_W  = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int TW    = 2 * EW;
    localparam int AW    = IDX_W + EW;
    localparam int DW    = EW + mwt_pkg::CFG_W;
    localparam logic [EW-1:0] MAX_E = EW'(MAX_DIM);

    function automatic logic [EW-1:0] clip(input logic [EW-1:0] v);
        return (v > MAX_E) ? MAX_E : v;
    endfunction

    logic [LC_W-1:0] r_load_count;
    logic [EW-1:0]   r_row;
    logic [EW-1:0]   r_col;
    logic            r_done;
    logic            r_started;
    logic            r_s1_valid;
    logic [mwt_pkg::DEST_W-1:0] r_dest;
    logic            r_last;

    logic [EW-1:0] rc, cc, er_c, ec_c, er, ec, rb, cb;
    logic [EW-1:0] cur_row, cur_col, row_inc, col_inc;
    logic [TW-1:0] total;
    logic [AW-1:0] addr_full;
    logic [DW-1:0] dest_full;
    logic          loaded, accept, is_load, in_win, drain_ok, issue, wrap, last_c;

    always_comb begin
        rc      = clip(EW'(i_cfg.row_count));
        cc      = clip(EW'(i_cfg.col_count));
        er_c    = clip(EW'(i_cfg.row_end));
        ec_c    = clip(EW'(i_cfg.col_end));
        er      = (er_c < rc) ? er_c : rc;
        ec      = (ec_c < cc) ? ec_c : cc;
        rb      = EW'(i_cfg.row_begin);
        cb      = EW'(i_cfg.col_begin);
        total   = TW'(rc) * TW'(cc);
        loaded  = TW'(r_load_count) >= total;
        cur_row = r_started ? r_row : rb;
        cur_col = r_started ? r_col : cb;
        row_inc = cur_row + EW'(1);
        col_inc = cur_col + EW'(1);
        wrap    = row_inc >= er;
        last_c  = wrap && (col_inc >= ec);
        in_win  = (cur_row < er) && (cur_col < ec);
    end

    assign accept   = i_valid && o_stat.ready;
    assign is_load  = mwt_pkg::t_op'(i_op) == mwt_pkg::OP_LOAD;
    assign drain_ok = accept && !is_load && loaded && !r_done;
    assign issue    = drain_ok && in_win;

    // source address row*col_count+col, destination index col*stride+row
    assign addr_full = AW'(cur_row[IDX_W-1:0]) * AW'(cc) + AW'(cur_col);
    assign dest_full = DW'(cur_col) * DW'(i_cfg.out_stride) + DW'(cur_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_done       <= 1'b0;
            r_started    <= 1'b0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (accept && is_load && !loaded) begin
                r_load_count <= r_load_count + LC_W'(1);
            end
            if (drain_ok) begin
                r_started <= 1'b1;
                if (!in_win) begin
                    r_done <= 1'b1;
                end else if (wrap) begin
                    r_row <= rb;
                    r_col <= col_inc;
                    if (last_c) begin
                        r_done <= 1'b1;
                    end
                end else begin
                    r_row <= row_inc;
                    r_col <= cur_col;
                end
            end
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (i_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_dest <= dest_full[mwt_pkg::DEST_W-1:0];
            r_last <= last_c;
        end
    end

    assign o_stat.ready       = !r_s1_valid || i_take;
    assign o_stat.s1_valid    = r_s1_valid;
    assign o_stat.window_done = r_done;
    assign o_mem_ctl.we       = accept && is_load && !loaded;
    assign o_mem_ctl.re       = issue;
    assign o_waddr            = r_load_count[ADDR_W-1:0];
    assign o_wdata            = i_elem;
    assign o_raddr            = addr_full[ADDR_W-1:0];
    assign o_dest             = r_dest;
    assign o_last             = r_last;

endmodule

[rtl/core/matrix_window_transpose_top.sv]
// Load item: written to the matrix store at the edge it is accepted; no result.
// Drain item: the store read is registered at the accepting edge and then moves into
// the output register once it is free, which sets the result valid. Throughput: one item
// per cycle unless stalled, set by the single write and read port of the store.
// Reset clears counters, window state, valid flags and config to their defaults; the
// matrix store is not cleared and holds nothing defined until loaded.
module matrix_window_transpose_top #(
    parameter int MAX_DIM      = 64,
    parameter int ELEMENT_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mwt_item_if.sink                          i_item,
    mwt_result_if.source                      o_result,
    input  logic                              i_cfg_we,
    input  logic [mwt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mwt_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    mwt_pkg::t_cfg      r_cfg;
    mwt_pkg::t_seq_stat seq_stat;
    mwt_pkg::t_mem_ctl  mem_ctl;

    logic [ADDR_W-1:0]          waddr, raddr;
    logic [ELEMENT_BITS-1:0]    wdata, rdata;
    logic [mwt_pkg::DEST_W-1:0] s1_dest;
    logic                       s1_last;
    logic                       take;

    logic                       r_out_valid;
    logic [ELEMENT_BITS-1:0]    r_out_elem;
    logic [mwt_pkg::DEST_W-1:0] r_out_dest;
    logic                       r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_count  <= 7'd64;
            r_cfg.col_count  <= 7'd64;
            r_cfg.row_begin  <= 6'd0;
            r_cfg.row_end    <= 7'd64;
            r_cfg.col_begin  <= 6'd0;
            r_cfg.col_end    <= 7'd64;
            r_cfg.out_stride <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (mwt_pkg::t_cfg_reg'(i_cfg_idx))
                mwt_pkg::REG_ROW_COUNT:  r_cfg.row_count  <= i_cfg_data;
                mwt_pkg::REG_COL_COUNT:  r_cfg.col_count  <= i_cfg_data;
                mwt_pkg::REG_ROW_BEGIN:  r_cfg.row_begin  <= i_cfg_data[5:0];
                mwt_pkg::REG_ROW_END:    r_cfg.row_end    <= i_cfg_data;
                mwt_pkg::REG_COL_BEGIN:  r_cfg.col_begin  <= i_cfg_data[5:0];
                mwt_pkg::REG_COL_END:    r_cfg.col_end    <= i_cfg_data;
                mwt_pkg::REG_OUT_STRIDE: r_cfg.out_stride <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mwt_seq #(
        .MAX_DIM      (MAX_DIM),
        .ELEMENT_BITS (ELEMENT_BITS),
        .ADDR_W       (ADDR_W)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_item.valid),
        .i_op      (i_item.operation),
        .i_elem    (i_item.element_in),
        .i_take    (take),
        .o_stat    (seq_stat),
        .o_mem_ctl (mem_ctl),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_raddr   (raddr),
        .o_dest    (s1_dest),
        .o_last    (s1_last)
    );

    mwt_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ELEMENT_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // read stage moves into the output register when that one is free
    assign take = seq_stat.s1_valid && (!r_out_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_elem <= rdata;
            r_out_dest <= s1_dest;
            r_out_last <= s1_last;
        end
    end

    assign i_item.ready            = seq_stat.ready;
    assign o_result.valid          = r_out_valid;
    assign o_result.element_out    = r_out_elem;
    assign o_result.dest_index     = r_out_dest;
    assign o_result.last_of_window = r_out_last;

    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_stat.s1_valid && !take |=> seq_stat.s1_valid)
        else $error("read stage item lost while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> seq_stat.s1_valid && r_out_valid)
        else $error("input stalled with free pipeline");

    a_no_read_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_stat.window_done |-> !mem_ctl.re)
        else $error("store read issued after window finished");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> seq_stat.window_done)
        else $error("last mark without finished window");

endmodule
